// File: rtl/bmlc_pkg.sv
// Package: shared widths, register indexes, reset values and types of the button LED controller.
package bmlc_pkg;

	localparam int TIMER_WIDTH_DEF = 16;

	localparam int DEB_W     = 8;
	localparam int LIM_W     = 16;
	localparam int PWM_W     = 4;
	localparam int MODE_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 3'd0,
		REG_LONG_PRESS = 3'd1,
		REG_FLASH_HALF = 3'd2,
		REG_PWM_PERIOD = 3'd3,
		REG_DIM_A_ON   = 3'd4,
		REG_DIM_B_ON   = 3'd5
	} cfg_idx_t;

	localparam logic [DEB_W-1:0] DEBOUNCE_RST   = 8'd20;
	localparam logic [LIM_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [LIM_W-1:0] FLASH_HALF_RST = 16'd500;
	localparam logic [PWM_W-1:0] PWM_PERIOD_RST = 4'd10;
	localparam logic [PWM_W-1:0] DIM_A_ON_RST   = 4'd5;
	localparam logic [PWM_W-1:0] DIM_B_ON_RST   = 4'd1;

	localparam logic [MODE_W-1:0] CODE_OFF   = 3'd0;
	localparam logic [MODE_W-1:0] CODE_FULL  = 3'd1;
	localparam logic [MODE_W-1:0] CODE_DIM_A = 3'd2;
	localparam logic [MODE_W-1:0] CODE_DIM_B = 3'd3;
	localparam logic [MODE_W-1:0] CODE_FLASH = 3'd4;

	typedef struct packed {
		logic [DEB_W-1:0] debounce_ticks;
		logic [LIM_W-1:0] long_press_ticks;
		logic [LIM_W-1:0] flash_half_ticks;
		logic [PWM_W-1:0] pwm_period_ticks;
		logic [PWM_W-1:0] dim_a_on_ticks;
		logic [PWM_W-1:0] dim_b_on_ticks;
	} cfg_t;

endpackage

// File: rtl/bmlc_in_if.sv
// Interface: tick word channel carrying the raw button level.
interface bmlc_in_if;
	logic valid;
	logic ready;
	logic raw_switch;

	modport source (output valid, output raw_switch, input ready);
	modport sink (input valid, input raw_switch, output ready);
endinterface

// File: rtl/bmlc_out_if.sv
// Interface: result word channel carrying LED level and mode code.
interface bmlc_out_if;
	import bmlc_pkg::*;
	logic              valid;
	logic              ready;
	logic              led_on;
	logic [MODE_W-1:0] mode_now;

	modport source (output valid, output led_on, output mode_now, input ready);
	modport sink (input valid, input led_on, input mode_now, output ready);
endinterface

// File: rtl/bmlc_cfg_if.sv
// Interface: configuration write channel with register index and data.
interface bmlc_cfg_if;
	import bmlc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/bmlc_cfg_regs.sv
// Configuration register file of the button LED controller.
module bmlc_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	bmlc_cfg_if.sink     cfg,
	output bmlc_pkg::cfg_t regs
);
	import bmlc_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_ticks   <= DEBOUNCE_RST;
			regs_q.long_press_ticks <= LONG_PRESS_RST;
			regs_q.flash_half_ticks <= FLASH_HALF_RST;
			regs_q.pwm_period_ticks <= PWM_PERIOD_RST;
			regs_q.dim_a_on_ticks   <= DIM_A_ON_RST;
			regs_q.dim_b_on_ticks   <= DIM_B_ON_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_DEBOUNCE:   regs_q.debounce_ticks   <= cfg.data[DEB_W-1:0];
				REG_LONG_PRESS: regs_q.long_press_ticks <= cfg.data[LIM_W-1:0];
				REG_FLASH_HALF: regs_q.flash_half_ticks <= cfg.data[LIM_W-1:0];
				REG_PWM_PERIOD: regs_q.pwm_period_ticks <= cfg.data[PWM_W-1:0];
				REG_DIM_A_ON:   regs_q.dim_a_on_ticks   <= cfg.data[PWM_W-1:0];
				REG_DIM_B_ON:   regs_q.dim_b_on_ticks   <= cfg.data[PWM_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

// File: rtl/bmlc_tick_core.sv
// Tick core: debounce, press timing, mode selection and LED drive state.
module bmlc_tick_core #(
	parameter int TIMER_WIDTH = bmlc_pkg::TIMER_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        raw,
	input  bmlc_pkg::cfg_t              regs,
	output logic                        led_nxt,
	output logic [bmlc_pkg::MODE_W-1:0] mode_nxt
);
	import bmlc_pkg::*;

	localparam int CW = (TIMER_WIDTH > LIM_W) ? TIMER_WIDTH : LIM_W;
	localparam logic [TIMER_WIDTH-1:0] T_MAX = '1;

	typedef enum logic [4:0] {
		M_OFF   = 5'b00001,
		M_FULL  = 5'b00010,
		M_DIM_A = 5'b00100,
		M_DIM_B = 5'b01000,
		M_FLASH = 5'b10000
	} mode_t;

	logic                   last_q, stable_q, active_q, led_q;
	logic [DEB_W-1:0]       hold_q;
	logic [TIMER_WIDTH-1:0] press_q, flash_q;
	logic [PWM_W-1:0]       phase_q;
	mode_t                  mode_q;

	logic                   last_n, stable_n, active_n, led_n;
	logic [DEB_W-1:0]       hold_n;
	logic [TIMER_WIDTH-1:0] press_n, flash_n;
	logic [PWM_W-1:0]       phase_n;
	mode_t                  mode_n;

	always_comb begin
		logic [PWM_W-1:0] on_ticks;
		last_n   = last_q;
		hold_n   = hold_q;
		stable_n = stable_q;
		active_n = active_q;
		press_n  = press_q;
		mode_n   = mode_q;
		phase_n  = phase_q;
		flash_n  = flash_q;
		led_n    = led_q;
		on_ticks = regs.dim_a_on_ticks;

		// debounce
		if (raw != last_q) begin
			last_n = raw;
			hold_n = '0;
		end else begin
			if (hold_q < regs.debounce_ticks)
				hold_n = hold_q + 1'b1;
			if (hold_n >= regs.debounce_ticks)
				stable_n = last_q;
		end

		// press timing and mode change on release
		if (!stable_n) begin
			if (!active_q) begin
				active_n = 1'b1;
				press_n  = '0;
			end
			if (press_n != T_MAX)
				press_n = press_n + 1'b1;
		end else begin
			if (active_q) begin
				if (CW'(press_q) >= CW'(regs.long_press_ticks)) begin
					mode_n = (mode_q == M_OFF) ? M_FULL : M_OFF;
				end else begin
					unique case (mode_q)
						M_FULL:  mode_n = M_DIM_A;
						M_DIM_A: mode_n = M_DIM_B;
						M_DIM_B: mode_n = M_FLASH;
						M_FLASH: mode_n = M_FULL;
						default: mode_n = mode_q;
					endcase
				end
				flash_n = '0;
			end
			active_n = 1'b0;
		end

		// LED drive
		if (mode_n == M_DIM_B)
			on_ticks = regs.dim_b_on_ticks;
		unique case (mode_n)
			M_OFF:  led_n = 1'b0;
			M_FULL: led_n = 1'b1;
			M_DIM_A, M_DIM_B: begin
				led_n   = (phase_q < on_ticks);
				phase_n = phase_q + 1'b1;
				if (phase_n >= regs.pwm_period_ticks)
					phase_n = '0;
			end
			M_FLASH: begin
				flash_n = flash_n + 1'b1;
				if (CW'(flash_n) >= CW'(regs.flash_half_ticks)) begin
					flash_n = '0;
					led_n   = ~led_q;
				end
			end
			default: led_n = led_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b1;
			hold_q   <= '0;
			stable_q <= 1'b1;
			active_q <= 1'b0;
			press_q  <= '0;
			mode_q   <= M_OFF;
			phase_q  <= '0;
			flash_q  <= '0;
			led_q    <= 1'b0;
		end else if (step) begin
			last_q   <= last_n;
			hold_q   <= hold_n;
			stable_q <= stable_n;
			active_q <= active_n;
			press_q  <= press_n;
			mode_q   <= mode_n;
			phase_q  <= phase_n;
			flash_q  <= flash_n;
			led_q    <= led_n;
		end
	end

	always_comb begin
		unique case (mode_n)
			M_FULL:  mode_nxt = CODE_FULL;
			M_DIM_A: mode_nxt = CODE_DIM_A;
			M_DIM_B: mode_nxt = CODE_DIM_B;
			M_FLASH: mode_nxt = CODE_FLASH;
			default: mode_nxt = CODE_OFF;
		endcase
	end

	assign led_nxt = led_n;
endmodule

// File: rtl/button_mode_led_controller.sv
// Top level of the button LED controller: input register, tick core, result register.
// Usage:
//   button: one word per time tick, raw_switch is the raw active-low button level.
//   result: one word per tick, led_on is the LED level after that tick and
//           mode_now the mode code (0 off, 1 full, 2 dim A, 3 dim B, 4 flash).
//   cfg:    register writes by index (debounce, long press, flash half period,
//           PWM period, dim A on ticks, dim B on ticks); unknown indexes are
//           dropped. Write only while no tick is in flight.
// Path: a word accepted is registered in the input register; its result is loaded
//   into the result register when the core advances and is valid from then on.
// Throughput: one tick per cycle while result is taken; the tick core updates all state in one
//   pass between the input register and the result register.
// Reset: arst_n clears the valid flags and the core state to released/off and loads the
//   register defaults; no word is pending afterwards.
// Stall: while result is held, the stored tick waits in the input register;
//   button.ready drops only when both registers are full and result.ready is low.
module button_mode_led_controller #(
	parameter int TIMER_WIDTH = bmlc_pkg::TIMER_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bmlc_in_if.sink    button,
	bmlc_out_if.source result,
	bmlc_cfg_if.sink   cfg
);
	import bmlc_pkg::*;

	cfg_t              regs;
	logic              valid_s1, raw_s1;
	logic              out_valid_q, led_q;
	logic [MODE_W-1:0] mode_q;
	logic              advance, led_nxt;
	logic [MODE_W-1:0] mode_nxt;

	bmlc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign button.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (button.valid && button.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (button.valid && button.ready)
			raw_s1 <= button.raw_switch;
	end

	bmlc_tick_core #(.TIMER_WIDTH(TIMER_WIDTH)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.raw      (raw_s1),
		.regs     (regs),
		.led_nxt  (led_nxt),
		.mode_nxt (mode_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_q  <= led_nxt;
			mode_q <= mode_nxt;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.led_on   = led_q;
	assign result.mode_now = mode_q;
endmodule
